FILE: design/rbfr_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the CRC16 step function for the bus frame receiver.
// No dependencies; used by every module of the receiver except the input stage.
package rbfr_pkg;

	localparam logic [15:0] CRC_POLY      = 16'h1002;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [7:0]  START_BYTE    = 8'hFD;
	localparam logic [7:0]  ESCAPE_BYTE   = 8'hFC;
	localparam logic [7:0]  ESCAPE_MARK   = 8'h80;
	localparam logic [7:0]  ZERO_BYTE     = 8'h00;
	localparam logic [7:0]  SAT_POS       = 8'hFF;

	localparam logic [7:0]  CMD_QUERY     = 8'h53;
	localparam logic [7:0]  CMD_PROG_DONE = 8'h67;
	localparam logic [7:0]  CMD_BOOT      = 8'h70;
	localparam logic [7:0]  CMD_SET       = 8'h73;

	localparam logic [3:0]  HDR_CTRL_POS   = 4'd4;
	localparam logic [3:0]  HDR_SENDER_END = 4'd9;
	localparam int          CTRL_SENDER_BIT = 3;
	localparam int          HEAD_DEPTH     = 4;

	typedef enum logic [2:0] {
		KIND_QUERY     = 3'd0,
		KIND_PROG_DONE = 3'd1,
		KIND_BOOT      = 3'd2,
		KIND_SET       = 3'd3,
		KIND_OTHER     = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		SET_OFF  = 2'd0,
		SET_ON   = 2'd1,
		SET_NONE = 2'd2
	} set_value_t;

	typedef struct packed {
		logic        crc_ok;
		kind_t       kind;
		logic [7:0]  actor_number;
		logic        actor_valid;
		set_value_t  set_value;
		logic [1:0]  sequence_number;
		logic [7:0]  frame_control;
		logic [7:0]  payload_length;
	} result_t;

	// one byte, MSB first, data into bit 0, augmented form
	function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		logic        top;
		c = crc_in;
		for (int i = 7; i >= 0; i--) begin
			top = c[15];
			c = {c[14:0], data[i]};
			if (top) begin
				c = c ^ CRC_POLY;
			end
		end
		return c;
	endfunction

endpackage

FILE: design/rbfr_in_stage.sv
`timescale 1ns / 1ps
// Input register stage: captures one received byte per accepted word.
// Depends on nothing but the clock and reset.
module rbfr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic accept;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

FILE: design/rbfr_frame_core.sv
`timescale 1ns / 1ps
// Frame parser: unescape, header collection, CRC16, payload capture and command decode.
// Depends on rbfr_pkg.
module rbfr_frame_core #(
	parameter int ACTOR_COUNT = 6
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       byte_s1,
	input  logic [31:0]      device_address_q,
	output logic             fire,
	output rbfr_pkg::result_t result
);

	logic        esc_q, esc_d;
	logic [3:0]  hdr_q, hdr_d;
	logic        len_taken_q, len_taken_d;
	logic [31:0] target_q, target_d;
	logic [7:0]  ctrl_q, ctrl_d;
	logic        match_q, match_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  ppos_q, ppos_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  head_q [rbfr_pkg::HEAD_DEPTH];
	logic [7:0]  head_n [rbfr_pkg::HEAD_DEPTH];
	logic        head_we;
	logic [15:0] crc_byte;
	logic [15:0] crc_fin;
	logic [7:0]  chx;

	function automatic logic actor_ok(input logic [7:0] a);
		return (a != 8'd0) && (a <= 8'(ACTOR_COUNT));
	endfunction

	assign chx      = esc_q ? (byte_s1 | rbfr_pkg::ESCAPE_MARK) : byte_s1;
	assign crc_byte = rbfr_pkg::crc_feed(crc_q, chx);
	assign crc_fin  = rbfr_pkg::crc_feed(rbfr_pkg::crc_feed(crc_byte, rbfr_pkg::ZERO_BYTE),
		rbfr_pkg::ZERO_BYTE);

	always_comb begin
		esc_d       = esc_q;
		hdr_d       = hdr_q;
		len_taken_d = len_taken_q;
		target_d    = target_q;
		ctrl_d      = ctrl_q;
		match_d     = match_q;
		len_d       = len_q;
		ppos_d      = ppos_q;
		crc_d       = crc_q;
		head_we     = 1'b0;
		fire        = 1'b0;
		if (step) begin
			if (byte_s1 == rbfr_pkg::ESCAPE_BYTE && !esc_q) begin
				esc_d = 1'b1;
			end else if (byte_s1 == rbfr_pkg::START_BYTE) begin
				esc_d       = 1'b0;
				hdr_d       = 4'd0;
				len_taken_d = 1'b0;
				ppos_d      = 8'd0;
				crc_d       = rbfr_pkg::crc_feed(rbfr_pkg::CRC_INIT, rbfr_pkg::START_BYTE);
			end else begin
				esc_d = 1'b0;
				if (!len_taken_q && hdr_q < rbfr_pkg::HDR_CTRL_POS) begin
					case (hdr_q[1:0])
						2'd0: target_d[31:24] = chx;
						2'd1: target_d[23:16] = chx;
						2'd2: target_d[15:8]  = chx;
						default: target_d[7:0] = chx;
					endcase
					hdr_d = hdr_q + 4'd1;
					crc_d = crc_byte;
				end else if (!len_taken_q && hdr_q == rbfr_pkg::HDR_CTRL_POS) begin
					ctrl_d  = chx;
					hdr_d   = rbfr_pkg::HDR_CTRL_POS + 4'd1;
					crc_d   = crc_byte;
					match_d = (target_q == device_address_q);
				end else if (!len_taken_q && ctrl_q[rbfr_pkg::CTRL_SENDER_BIT]
						&& hdr_q < rbfr_pkg::HDR_SENDER_END) begin
					hdr_d = hdr_q + 4'd1;
					crc_d = crc_byte;
				end else if (!len_taken_q) begin
					len_taken_d = 1'b1;
					len_d       = chx;
					crc_d       = crc_byte;
				end else if (match_q) begin
					head_we = (ppos_q < 8'(rbfr_pkg::HEAD_DEPTH));
					if (({1'b0, ppos_q} + 9'd1) == {1'b0, len_q}) begin
						fire        = 1'b1;
						crc_d       = crc_fin;
						ppos_d      = 8'd0;
						hdr_d       = 4'd0;
						len_taken_d = 1'b0;
					end else begin
						crc_d = crc_byte;
						if (ppos_q != rbfr_pkg::SAT_POS) begin
							ppos_d = ppos_q + 8'd1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < rbfr_pkg::HEAD_DEPTH; i++) begin
			head_n[i] = head_q[i];
		end
		if (head_we) begin
			head_n[ppos_q[1:0]] = chx;
		end
	end

	always_comb begin
		result.crc_ok          = (crc_fin == 16'd0);
		result.kind            = rbfr_pkg::KIND_OTHER;
		result.actor_number    = 8'd0;
		result.actor_valid     = 1'b0;
		result.set_value       = rbfr_pkg::SET_NONE;
		result.sequence_number = ctrl_q[2:1];
		result.frame_control   = ctrl_q;
		result.payload_length  = len_q;
		if (result.crc_ok) begin
			unique case (head_n[0])
				rbfr_pkg::CMD_QUERY: begin
					result.kind         = rbfr_pkg::KIND_QUERY;
					result.actor_number = head_n[1];
					result.actor_valid  = actor_ok(head_n[1]);
				end
				rbfr_pkg::CMD_PROG_DONE: begin
					result.kind = rbfr_pkg::KIND_PROG_DONE;
				end
				rbfr_pkg::CMD_BOOT: begin
					result.kind = rbfr_pkg::KIND_BOOT;
				end
				rbfr_pkg::CMD_SET: begin
					result.kind         = rbfr_pkg::KIND_SET;
					result.actor_number = head_n[2];
					result.actor_valid  = actor_ok(head_n[2]);
					if (head_n[3] == 8'd0) begin
						result.set_value = rbfr_pkg::SET_OFF;
					end else if (head_n[3] == 8'd1) begin
						result.set_value = rbfr_pkg::SET_ON;
					end
				end
				default: begin
					result.kind = rbfr_pkg::KIND_OTHER;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q       <= 1'b0;
			hdr_q       <= 4'd0;
			len_taken_q <= 1'b0;
			target_q    <= 32'd0;
			ctrl_q      <= 8'd0;
			match_q     <= 1'b0;
			len_q       <= 8'd0;
			ppos_q      <= 8'd0;
			crc_q       <= rbfr_pkg::CRC_INIT;
		end else begin
			esc_q       <= esc_d;
			hdr_q       <= hdr_d;
			len_taken_q <= len_taken_d;
			target_q    <= target_d;
			ctrl_q      <= ctrl_d;
			match_q     <= match_d;
			len_q       <= len_d;
			ppos_q      <= ppos_d;
			crc_q       <= crc_d;
		end
	end

	// payload head: no reset; entries not written in the current frame keep older values
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_q[ppos_q[1:0]] <= chx;
		end
	end

`ifndef NO_ASSERTIONS
	a_fire_needs_match: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (len_taken_q && match_q && step))
		else $error("frame completed without length or address match");

	a_hdr_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_q <= rbfr_pkg::HDR_SENDER_END)
		else $error("header position out of range");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (hdr_q == 4'd0 && !len_taken_q && ppos_q == 8'd0))
		else $error("frame positions not cleared after completion");

	a_bad_crc_result: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !result.crc_ok) |->
		(result.kind == rbfr_pkg::KIND_OTHER && !result.actor_valid
		&& result.set_value == rbfr_pkg::SET_NONE))
		else $error("bad CRC frame decoded as a command");
`endif

endmodule

FILE: design/rbfr_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one decoded frame result until the consumer takes it.
// Depends on rbfr_pkg.
module rbfr_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  rbfr_pkg::result_t result_in,
	input  logic              out_stall,
	output logic              out_valid,
	output rbfr_pkg::result_t result_q
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

FILE: design/rs485_bus_frame_receiver.sv
`timescale 1ns / 1ps
// Top level of the bus frame receiver: input stage, frame parser, result register.
// Depends on rbfr_pkg, rbfr_in_stage, rbfr_frame_core and rbfr_out_reg.
//
// Takes one raw bus byte per clock on the rx_byte channel and emits one result word per
// completed frame (CRC status and decoded command). An accepted byte is registered, then
// parsed when it leaves the input register; a frame result is loaded into the result
// register when its last payload byte is parsed. Sustained rate is one byte per cycle
// while in_stall is low; the parser step (unescape, header tracking, command decode and a
// 24-bit unrolled CRC16 update) is the only logic between the input register and the
// result register. in_stall rises only while a result is held by out_stall and another
// byte waits in the input register. device_address is written through the cfg channel,
// which is always ready, and must only change while the receiver is idle.
module rs485_bus_frame_receiver #(
	parameter int ACTOR_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] device_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        crc_ok,
	output logic [2:0]  command_kind,
	output logic [7:0]  actor_number,
	output logic        actor_valid,
	output logic [1:0]  set_value,
	output logic [1:0]  sequence_number,
	output logic [7:0]  frame_control,
	output logic [7:0]  payload_length
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              advance;
	logic              fire;
	logic [31:0]       device_address_q;
	rbfr_pkg::result_t result;
	rbfr_pkg::result_t result_q;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			device_address_q <= device_address;
		end
	end

	rbfr_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	rbfr_frame_core #(
		.ACTOR_COUNT (ACTOR_COUNT)
	) u_frame_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step             (advance),
		.byte_s1          (byte_s1),
		.device_address_q (device_address_q),
		.fire             (fire),
		.result           (result)
	);

	rbfr_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result_in (result),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result_q  (result_q)
	);

	assign crc_ok          = result_q.crc_ok;
	assign command_kind    = result_q.kind;
	assign actor_number    = result_q.actor_number;
	assign actor_valid     = result_q.actor_valid;
	assign set_value       = result_q.set_value;
	assign sequence_number = result_q.sequence_number;
	assign frame_control   = result_q.frame_control;
	assign payload_length  = result_q.payload_length;

`ifndef NO_ASSERTIONS
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && valid_s1))
		else $error("input stalled without output backpressure");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> (!out_valid || !out_stall))
		else $error("result register overwritten while held");
`endif

endmodule

FILE: tb/rbfr_frame_checker.sv
`timescale 1ns / 1ps
// Frame checker for the bus frame receiver testbench: follows the accepted bytes and the
// device address writes, predicts every result word and compares it on the output channel.
// Depends on rbfr_pkg.
module rbfr_frame_checker #(
	parameter int ACTOR_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [31:0] device_address,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        crc_ok,
	input  logic [2:0]  command_kind,
	input  logic [7:0]  actor_number,
	input  logic        actor_valid,
	input  logic [1:0]  set_value,
	input  logic [1:0]  sequence_number,
	input  logic [7:0]  frame_control,
	input  logic [7:0]  payload_length,
	output int unsigned mismatches,
	output int unsigned frames_due
);
	import rbfr_pkg::*;

	localparam logic [7:0] HDR_DONE    = 8'hFF;
	localparam logic [7:0] SENDER_FLAG = 8'h08;

	logic [31:0] node_addr;
	logic [31:0] dest_addr;
	logic        esc_armed;
	logic        addr_hit;
	logic [7:0]  hdr_pos;
	logic [7:0]  ctrl_byte;
	logic [7:0]  len_byte;
	logic [7:0]  pay_pos;
	logic [15:0] crc_reg;
	logic [7:0]  head [4];
	result_t     frame_results [$];

	function automatic logic [15:0] crc_shift(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] r;
		logic        carry;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			carry = r[15];
			r = (r << 1) | 16'(data[7 - k]);
			if (carry) begin
				r = r ^ CRC_POLY;
			end
		end
		return r;
	endfunction

	task automatic close_frame();
		result_t r;
		crc_reg = crc_shift(crc_shift(crc_reg, ZERO_BYTE), ZERO_BYTE);
		pay_pos = '0;
		hdr_pos = '0;
		r.crc_ok = (crc_reg == 16'h0000);
		r.kind = KIND_OTHER;
		r.actor_number = '0;
		r.set_value = SET_NONE;
		r.sequence_number = ctrl_byte[2:1];
		r.frame_control = ctrl_byte;
		r.payload_length = len_byte;
		if (r.crc_ok) begin
			case (head[0])
				CMD_QUERY: begin
					r.kind = KIND_QUERY;
					r.actor_number = head[1];
				end
				CMD_PROG_DONE: r.kind = KIND_PROG_DONE;
				CMD_BOOT: r.kind = KIND_BOOT;
				CMD_SET: begin
					r.kind = KIND_SET;
					r.actor_number = head[2];
					if (head[3] == 8'd0) begin
						r.set_value = SET_OFF;
					end else if (head[3] == 8'd1) begin
						r.set_value = SET_ON;
					end
				end
				default: ;
			endcase
		end
		r.actor_valid = (r.actor_number >= 1 && r.actor_number <= ACTOR_COUNT);
		frame_results.push_back(r);
	endtask

	task automatic take_byte(input logic [7:0] raw);
		logic [7:0] ch;
		ch = raw;
		if (ch == ESCAPE_BYTE && !esc_armed) begin
			esc_armed = 1'b1;
			return;
		end
		// raw start byte always wins, pending escape is dropped
		if (ch == START_BYTE) begin
			esc_armed = 1'b0;
			hdr_pos = '0;
			pay_pos = '0;
			crc_reg = crc_shift(CRC_INIT, ch);
			return;
		end
		if (esc_armed) begin
			ch = ch | ESCAPE_MARK;
			esc_armed = 1'b0;
		end
		if (hdr_pos < 4) begin
			dest_addr[8 * (3 - hdr_pos) +: 8] = ch;
			hdr_pos++;
			crc_reg = crc_shift(crc_reg, ch);
		end else if (hdr_pos == 4) begin
			ctrl_byte = ch;
			hdr_pos = 8'd5;
			crc_reg = crc_shift(crc_reg, ch);
			addr_hit = (dest_addr == node_addr);
		end else if ((ctrl_byte & SENDER_FLAG) != 0 && hdr_pos < 9) begin
			hdr_pos++;
			crc_reg = crc_shift(crc_reg, ch);
		end else if (hdr_pos != HDR_DONE) begin
			hdr_pos = HDR_DONE;
			len_byte = ch;
			crc_reg = crc_shift(crc_reg, ch);
		end else if (addr_hit) begin
			if (pay_pos < 4) begin
				head[pay_pos[1:0]] = ch;
			end
			crc_reg = crc_shift(crc_reg, ch);
			if (pay_pos + 1 == len_byte) begin
				close_frame();
			end else if (pay_pos < 8'd255) begin
				pay_pos++;
			end
		end
	endtask

	task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	task automatic match_result();
		result_t want;
		if (frame_results.size() == 0) begin
			$error("result word with no frame pending");
			mismatches++;
			return;
		end
		want = frame_results.pop_front();
		check_field("crc_ok", 8'(want.crc_ok), 8'(crc_ok));
		check_field("command_kind", 8'(want.kind), 8'(command_kind));
		check_field("actor_number", want.actor_number, actor_number);
		check_field("actor_valid", 8'(want.actor_valid), 8'(actor_valid));
		check_field("set_value", 8'(want.set_value), 8'(set_value));
		check_field("sequence_number", 8'(want.sequence_number), 8'(sequence_number));
		check_field("frame_control", want.frame_control, frame_control);
		check_field("payload_length", want.payload_length, payload_length);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr = '0;
			dest_addr = '0;
			esc_armed = 1'b0;
			addr_hit = 1'b0;
			hdr_pos = '0;
			ctrl_byte = '0;
			len_byte = '0;
			pay_pos = '0;
			crc_reg = CRC_INIT;
			frame_results.delete();
			mismatches = 0;
			frames_due = 0;
		end else begin
			if (out_valid && !out_stall) begin
				match_result();
			end
			if (cfg_valid && cfg_ready) begin
				node_addr = device_address;
			end
			if (in_valid && !in_stall) begin
				take_byte(rx_byte);
			end
			frames_due = frame_results.size();
		end
	end

endmodule

FILE: tb/rs485_bus_frame_receiver_tb.sv
`timescale 1ns / 1ps
// Testbench top for the bus frame receiver: clock, reset, byte and device address stimulus,
// output stall patterns and the verdict. Depends on rbfr_pkg, the receiver and rbfr_frame_checker.
module rs485_bus_frame_receiver_tb;
	import rbfr_pkg::*;

	localparam int          ACTOR_COUNT   = 6;
	localparam int unsigned ITEM_TARGET   = 1200;
	localparam int unsigned PHASES        = 6;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned HOLD_CYCLES   = 300;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES  = 40;
	localparam logic [7:0]  SENDER_FLAG   = 8'h08;

	typedef logic [7:0] octets_t [$];
	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] device_address;
	logic        out_valid;
	logic        out_stall;
	logic        crc_ok;
	logic [2:0]  command_kind;
	logic [7:0]  actor_number;
	logic        actor_valid;
	logic [1:0]  set_value;
	logic [1:0]  sequence_number;
	logic [7:0]  frame_control;
	logic [7:0]  payload_length;

	int unsigned mismatches;
	int unsigned frames_due;
	int unsigned burst_left;
	int unsigned bytes_sent;
	int unsigned hold_asks;
	logic [31:0] node_addr;

	rs485_bus_frame_receiver #(.ACTOR_COUNT(ACTOR_COUNT)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.device_address(device_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.crc_ok(crc_ok),
		.command_kind(command_kind),
		.actor_number(actor_number),
		.actor_valid(actor_valid),
		.set_value(set_value),
		.sequence_number(sequence_number),
		.frame_control(frame_control),
		.payload_length(payload_length)
	);

	rbfr_frame_checker #(.ACTOR_COUNT(ACTOR_COUNT)) frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.device_address(device_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.crc_ok(crc_ok),
		.command_kind(command_kind),
		.actor_number(actor_number),
		.actor_valid(actor_valid),
		.set_value(set_value),
		.sequence_number(sequence_number),
		.frame_control(frame_control),
		.payload_length(payload_length),
		.mismatches(mismatches),
		.frames_due(frames_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	// output stall patterns; a hold request forces one long stall
	initial begin : stall_pattern
		stall_mode_t mode;
		int unsigned span;
		int unsigned period;
		int unsigned hold_seen;
		out_stall = 1'b0;
		hold_seen = 0;
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			span = $urandom_range(20, 300);
			period = $urandom_range(2, 9);
			for (int unsigned k = 0; k < span; k++) begin
				@(negedge clk);
				if (hold_asks != hold_seen) begin
					hold_seen = hold_asks;
					out_stall = 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				case (mode)
					STALL_NONE: out_stall = 1'b0;
					STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
					default: out_stall = ((k % period) < period / 2);
				endcase
			end
		end
	end

	function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] r;
		r = acc;
		for (int i = 7; i >= 0; i--) begin
			r = {r[14:0], data[i]} ^ (r[15] ? CRC_POLY : 16'h0000);
		end
		return r;
	endfunction

	function automatic octets_t body_of(input int unsigned n, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2, input logic [7:0] b3);
		octets_t q;
		logic [7:0] all [4];
		all = '{b0, b1, b2, b3};
		for (int unsigned i = 0; i < n; i++) begin
			q.push_back(all[i]);
		end
		return q;
	endfunction

	function automatic logic [7:0] pick_actor();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'(ACTOR_COUNT);
			3: return 8'(ACTOR_COUNT + 1);
			4: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic octets_t pick_body();
		octets_t q;
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			q = body_of(2, CMD_QUERY, pick_actor(), 8'h00, 8'h00);
		end else if (sel < 4) begin
			q = body_of(4, CMD_SET, 8'($urandom), pick_actor(), 8'($urandom_range(0, 3)));
			if ($urandom_range(0, 3) == 0) begin
				q[3] = 8'($urandom);
			end
		end else if (sel == 4) begin
			q = body_of(1, CMD_PROG_DONE, 8'h00, 8'h00, 8'h00);
		end else if (sel == 5) begin
			q = body_of(1, CMD_BOOT, 8'h00, 8'h00, 8'h00);
		end else if (sel == 6) begin
			q = body_of(0, 8'h00, 8'h00, 8'h00, 8'h00);
		end else begin
			repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
		end
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(0, 6)) q.push_back(8'($urandom));
		end
		if ($urandom_range(0, 39) == 0) begin
			repeat ($urandom_range(40, 80)) q.push_back(8'($urandom));
		end
		return q;
	endfunction

	// one word on the byte channel, sender idles between bursts
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 500)
			                                          : $urandom_range(1, 30);
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		burst_left--;
		@(negedge clk);
		in_valid = 1'b1;
		rx_byte = b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic push_wire(input logic [7:0] b);
		if (b == START_BYTE || b == ESCAPE_BYTE || (b[7] && $urandom_range(0, 7) == 0)) begin
			push_byte(ESCAPE_BYTE);
			if (b == ESCAPE_BYTE && $urandom_range(0, 1) == 1) begin
				push_byte(ESCAPE_BYTE);
			end else begin
				push_byte(b & ~ESCAPE_MARK);
			end
		end else begin
			push_byte(b);
		end
	endtask

	task automatic send_frame(input logic [31:0] dest, input logic [7:0] ctrl,
			input octets_t body, input int len_adj, input bit corrupt, input bit lead);
		octets_t lb;
		logic [15:0] crc;
		crc = CRC_INIT;
		if (lead) begin
			crc = crc16_step(crc, START_BYTE);
		end
		for (int i = 3; i >= 0; i--) begin
			lb.push_back(dest[8 * i +: 8]);
		end
		lb.push_back(ctrl);
		if ((ctrl & SENDER_FLAG) != 0) begin
			repeat (4) lb.push_back(8'($urandom));
		end
		lb.push_back(8'(int'(body.size()) + 2 + len_adj));
		foreach (body[i]) begin
			lb.push_back(body[i]);
		end
		foreach (lb[i]) begin
			crc = crc16_step(crc, lb[i]);
		end
		crc = crc16_step(crc16_step(crc, ZERO_BYTE), ZERO_BYTE);
		if (corrupt) begin
			crc = crc ^ (16'h0001 << $urandom_range(0, 15));
		end
		lb.push_back(crc[15:8]);
		lb.push_back(crc[7:0]);
		if (lead) begin
			push_byte(START_BYTE);
		end
		foreach (lb[i]) begin
			push_wire(lb[i]);
		end
	endtask

	task automatic send_random_frame();
		logic [31:0] dest;
		int          len_adj;
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel < 14) begin
			dest = node_addr;
		end else if (sel < 17) begin
			dest = node_addr ^ (32'h1 << $urandom_range(0, 31));
		end else begin
			dest = $urandom;
		end
		len_adj = 0;
		if ($urandom_range(0, 19) == 0) begin
			len_adj = ($urandom_range(0, 1) == 1) ? int'($urandom_range(1, 3))
			                                       : -int'($urandom_range(1, 3));
		end
		send_frame(dest, 8'($urandom), pick_body(), len_adj, $urandom_range(0, 15) == 0,
			$urandom_range(0, 31) != 0);
	endtask

	task automatic settle(input int unsigned tail);
		@(negedge clk);
		in_valid = 1'b0;
		while (frames_due != 0) @(negedge clk);
		repeat (tail) @(negedge clk);
	endtask

	task automatic write_device_address(input logic [31:0] addr);
		settle(SETTLE_CYCLES);
		@(negedge clk);
		cfg_valid = 1'b1;
		device_address = addr;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
		node_addr = addr;
	endtask

	initial begin : stimulus
		octets_t     junk;
		int unsigned phase_end;
		logic [31:0] addr;
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		cfg_valid = 1'b0;
		device_address = '0;
		burst_left = 0;
		bytes_sent = 0;
		hold_asks = 0;
		node_addr = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// header straight after reset with no start byte; fills all four head bytes
		send_frame(node_addr, 8'h02, body_of(4, CMD_SET, 8'h00, 8'(ACTOR_COUNT), 8'h01),
			0, 1'b0, 1'b0);
		send_frame(node_addr, 8'h06, body_of(2, CMD_QUERY, 8'h01, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		write_device_address(32'hFFFF_FFFF);
		send_frame(node_addr, 8'h0E, body_of(2, CMD_QUERY, 8'(ACTOR_COUNT + 1), 8'h00, 8'h00),
			0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h00, body_of(2, CMD_QUERY, 8'h00, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'hFF, body_of(2, CMD_QUERY, 8'hFF, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h04, body_of(4, CMD_SET, 8'h11, 8'h01, 8'h00), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h08, body_of(4, CMD_SET, 8'hFD, 8'hFF, 8'h02), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h80, body_of(4, CMD_SET, 8'hFC, 8'(ACTOR_COUNT), 8'hFF),
			0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h01, body_of(1, CMD_PROG_DONE, 8'h00, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h02, body_of(1, CMD_BOOT, 8'h00, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h03, body_of(3, 8'h00, 8'h12, 8'h34, 8'h00), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h05, body_of(2, 8'hFF, 8'hFE, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		// bad CRC
		send_frame(node_addr, 8'h06, body_of(2, CMD_QUERY, 8'h02, 8'h00, 8'h00), 0, 1'b1, 1'b1);
		// foreign target, payload ignored
		send_frame(32'h7FFF_FFFF, 8'h00, body_of(2, CMD_QUERY, 8'h03, 8'h00, 8'h00),
			0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h00, body_of(1, CMD_PROG_DONE, 8'h00, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		// CRC bytes only, then a single payload byte
		send_frame(node_addr, 8'h02, body_of(0, 8'h00, 8'h00, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		send_frame(node_addr, 8'h04, body_of(0, 8'h00, 8'h00, 8'h00, 8'h00), -1, 1'b0, 1'b1);
		// escape right before the start byte
		push_byte(ESCAPE_BYTE);
		send_frame(node_addr, 8'h06, body_of(1, CMD_BOOT, 8'h00, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		// header cut short by a new start byte
		push_byte(START_BYTE);
		push_byte(8'h7F);
		push_byte(8'h12);
		send_frame(node_addr, 8'h00, body_of(2, CMD_QUERY, 8'h04, 8'h00, 8'h00), 0, 1'b0, 1'b1);
		// zero length: never completes, position saturates
		repeat (300) junk.push_back(8'($urandom));
		send_frame(node_addr, 8'h04, junk, -302, 1'b0, 1'b1);
		send_frame(node_addr, 8'h02, body_of(4, CMD_SET, 8'h00, 8'h05, 8'h01), 0, 1'b0, 1'b1);

		for (int unsigned phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: addr = 32'h0000_0000;
				1: addr = 32'hFFFF_FFFF;
				2: addr = 32'h8000_0001;
				3: addr = 32'h5AA5_0FF0;
				default: addr = $urandom;
			endcase
			write_device_address(addr);
			if (phase == 1 || phase == 4) begin
				hold_asks++;
			end
			phase_end = bytes_sent + ITEM_TARGET / PHASES;
			while (bytes_sent < phase_end) begin
				case ($urandom_range(0, 19))
					0: repeat ($urandom_range(1, 10)) push_byte(8'($urandom));
					1: begin
						push_byte(START_BYTE);
						repeat ($urandom_range(1, 8)) push_wire(8'($urandom));
					end
					default: send_random_frame();
				endcase
			end
		end

		settle(DRAIN_CYCLES);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: sim.f
design/rbfr_pkg.sv
design/rbfr_in_stage.sv
design/rbfr_frame_core.sv
design/rbfr_out_reg.sv
design/rs485_bus_frame_receiver.sv
tb/rbfr_frame_checker.sv
tb/rs485_bus_frame_receiver_tb.sv
